[sv/mfa_pkg.sv]
// Shared types, character codes and helpers for the format-to-ASCII stream core.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package mfa_pkg;

    // Character codes
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    // Digit scratch store: ten decimal digits cover any 32-bit magnitude
    localparam int          DIGIT_DEPTH = 10;
    localparam int          CNT_W       = $clog2(DIGIT_DEPTH + 1);
    localparam int          IDX_W       = $clog2(DIGIT_DEPTH);

    // floor(x * RECIP_10 / 2^35) == floor(x / 10) for every 32-bit x
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // Default depth of the command queue between front and back
    localparam int          QUEUE_DEPTH = 2;

    // Command kinds handed from the front to the back
    typedef enum logic [1:0] {
        KIND_ECHO,
        KIND_DEC,
        KIND_HEX
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ch;
        logic [31:0] arg;
    } t_cmd;

    // Queue status seen by the producer and the consumer
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_MUL,
        ST_DIV,
        ST_HEX,
        ST_EMIT
    } t_state;

    // One digit value to its lowercase ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d < 4'd10) begin
            return CH_ZERO + {4'd0, d};
        end else begin
            return CH_A + {4'd0, d} - 8'd10;
        end
    endfunction

endpackage

[sv/mfa_front.sv]
// Front end: accepts format bytes, tracks a held-back '%', and turns every byte but
// an opening '%' into an echo or conversion command. Depends on mfa_pkg.
`timescale 1ns / 1ps

module mfa_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_format_byte,
    input  logic [31:0]         i_argument_word,
    input  logic                i_string_end,
    output logic                o_push,
    output mfa_pkg::t_cmd       o_cmd
);

    logic r_pending;
    logic n_pending;

    // Classify the byte against the pending '%'
    always_comb begin
        o_cmd.ch   = i_format_byte;
        o_cmd.arg  = i_argument_word;
        o_cmd.kind = mfa_pkg::KIND_ECHO;
        o_push     = 1'b0;
        n_pending  = r_pending;
        if (i_accept) begin
            if (r_pending) begin
                o_push    = 1'b1;
                n_pending = 1'b0;
                if (i_format_byte == mfa_pkg::CH_D) begin
                    o_cmd.kind = mfa_pkg::KIND_DEC;
                end else if (i_format_byte == mfa_pkg::CH_X) begin
                    o_cmd.kind = mfa_pkg::KIND_HEX;
                end
            end else if (i_format_byte == mfa_pkg::CH_PERCENT) begin
                n_pending = ~i_string_end;
            end else begin
                o_push = 1'b1;
            end
            // end of string never leaves a '%' waiting
            if (i_string_end) begin
                n_pending = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else begin
            r_pending <= n_pending;
        end
    end

endmodule

[sv/mfa_queue.sv]
// Small command queue between the front and back ends.
// Depends on mfa_pkg for the command type.
`timescale 1ns / 1ps

module mfa_queue #(
    parameter int DEPTH = mfa_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mfa_pkg::t_cmd       i_cmd,
    input  logic                i_pop,
    output mfa_pkg::t_cmd       o_cmd,
    output mfa_pkg::t_qstat     o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mfa_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push & ~o_stat.full;
    assign do_pop       = i_pop & ~o_stat.empty;
    assign o_cmd        = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("command queue overfilled");
`endif

endmodule

[sv/mfa_back.sv]
// Back end: runs echo and conversion commands, producing digits into a scratch
// store and emitting characters through an output register. Depends on mfa_pkg.
`timescale 1ns / 1ps

module mfa_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mfa_pkg::t_cmd       i_cmd,
    input  mfa_pkg::t_qstat     i_qstat,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_text_char,
    output logic                o_run_last
);

    localparam int CNT_W = mfa_pkg::CNT_W;
    localparam int IDX_W = mfa_pkg::IDX_W;

    mfa_pkg::t_state r_state;
    mfa_pkg::t_state n_state;

    logic [31:0]      r_mag;
    logic [63:0]      r_prod;
    logic [CNT_W-1:0] r_cnt;
    logic [3:0]       r_digits [mfa_pkg::DIGIT_DEPTH];
    logic             r_ovalid;
    logic [7:0]       r_char;
    logic             r_last;

    logic             slot_free;
    logic             load;
    logic [7:0]       load_char;
    logic             load_last;
    logic [28:0]      quot;
    logic [31:0]      rem;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;

    assign slot_free = ~r_ovalid | ~i_stall;
    assign quot      = r_prod[63:mfa_pkg::RECIP_SHIFT];
    assign rem       = r_mag - ({3'd0, quot} << 3) - ({3'd0, quot} << 1);
    assign wr_idx    = r_cnt[IDX_W-1:0];
    assign rd_idx    = IDX_W'(r_cnt - 1'b1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mfa_pkg::ST_IDLE: begin
                if (!i_qstat.empty && slot_free) begin
                    case (i_cmd.kind)
                        mfa_pkg::KIND_DEC:
                            n_state = i_cmd.arg[31] ? mfa_pkg::ST_SIGN : mfa_pkg::ST_MUL;
                        mfa_pkg::KIND_HEX: n_state = mfa_pkg::ST_HEX;
                        default:           n_state = mfa_pkg::ST_IDLE;
                    endcase
                end
            end
            mfa_pkg::ST_SIGN: begin
                if (slot_free) begin
                    n_state = mfa_pkg::ST_MUL;
                end
            end
            mfa_pkg::ST_MUL: n_state = mfa_pkg::ST_DIV;
            mfa_pkg::ST_DIV: begin
                n_state = (quot == '0) ? mfa_pkg::ST_EMIT : mfa_pkg::ST_MUL;
            end
            mfa_pkg::ST_HEX: begin
                if (r_mag[31:4] == '0) begin
                    n_state = mfa_pkg::ST_EMIT;
                end
            end
            mfa_pkg::ST_EMIT: begin
                if (slot_free && r_cnt == CNT_W'(1)) begin
                    n_state = mfa_pkg::ST_IDLE;
                end
            end
            default: n_state = mfa_pkg::ST_IDLE;
        endcase
    end

    // Control outputs: queue pop and output register load
    always_comb begin
        o_pop     = 1'b0;
        load      = 1'b0;
        load_char = i_cmd.ch;
        load_last = 1'b1;
        case (r_state)
            mfa_pkg::ST_IDLE: begin
                if (!i_qstat.empty && slot_free) begin
                    o_pop = 1'b1;
                    load  = (i_cmd.kind != mfa_pkg::KIND_DEC) &&
                            (i_cmd.kind != mfa_pkg::KIND_HEX);
                end
            end
            mfa_pkg::ST_SIGN: begin
                load      = slot_free;
                load_char = mfa_pkg::CH_MINUS;
                load_last = 1'b0;
            end
            mfa_pkg::ST_EMIT: begin
                load      = slot_free;
                load_last = (r_cnt == CNT_W'(1));
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    // Conversion datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            mfa_pkg::ST_IDLE: begin
                r_cnt <= '0;
                if (i_cmd.kind == mfa_pkg::KIND_DEC && i_cmd.arg[31]) begin
                    r_mag <= 32'd0 - i_cmd.arg;
                end else begin
                    r_mag <= i_cmd.arg;
                end
            end
            mfa_pkg::ST_MUL: begin
                r_prod <= r_mag * mfa_pkg::RECIP_10;
            end
            mfa_pkg::ST_DIV: begin
                r_digits[wr_idx] <= rem[3:0];
                r_mag            <= {3'd0, quot};
                r_cnt            <= r_cnt + 1'b1;
            end
            mfa_pkg::ST_HEX: begin
                r_digits[wr_idx] <= r_mag[3:0];
                r_mag            <= r_mag >> 4;
                r_cnt            <= r_cnt + 1'b1;
            end
            mfa_pkg::ST_EMIT: begin
                if (slot_free) begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // State and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mfa_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Digits are read from the store straight into the output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_state == mfa_pkg::ST_EMIT) begin
                r_char <= mfa_pkg::digit_char(r_digits[rd_idx]);
            end else begin
                r_char <= load_char;
            end
            r_last <= load_last;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_text_char = r_char;
    assign o_run_last  = r_last;

`ifndef SYNTHESIS
    a_emit_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfa_pkg::ST_EMIT) |-> (r_cnt != '0))
        else $error("emitting with an empty digit store");

    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == mfa_pkg::ST_DIV) || (r_state == mfa_pkg::ST_HEX)) |->
            (r_cnt < CNT_W'(mfa_pkg::DIGIT_DEPTH)))
        else $error("digit store overrun");

    a_run_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfa_pkg::ST_EMIT && n_state == mfa_pkg::ST_IDLE) |=>
            (r_ovalid && r_last))
        else $error("conversion ended without a last character");
`endif

endmodule

[sv/mini_format_to_ascii_stream_core.sv]
// Echoed bytes pass through the command queue and then the output register.
// The back end sequences commands: echoes go back to back while the output is not stalled;
// %x shifts out hex digits and %d sends an optional sign, then a reciprocal multiply per digit.
// Input is taken whenever the command queue has room, so bytes stream ahead of emission.
// Reset (i_rst_n, synchronous, active low) clears pending '%', queue and sequencer.
`timescale 1ns / 1ps

module mini_format_to_ascii_stream_core #(
    parameter int QDEPTH = mfa_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_format_byte,
    input  logic [31:0] i_argument_word,
    input  logic        i_string_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_text_char,
    output logic        o_run_last
);

    logic             accept;
    logic             push;
    logic             pop;
    mfa_pkg::t_cmd    push_cmd;
    mfa_pkg::t_cmd    head_cmd;
    mfa_pkg::t_qstat  qstat;

    assign o_stall = qstat.full;
    assign accept  = i_valid & ~qstat.full;

    mfa_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_format_byte   (i_format_byte),
        .i_argument_word (i_argument_word),
        .i_string_end    (i_string_end),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    mfa_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (qstat)
    );

    mfa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_text_char (o_text_char),
        .o_run_last  (o_run_last)
    );

endmodule

[dv/mini_format_to_ascii_stream_core_test.sv]
// Self-checking testbench for mini_format_to_ascii_stream_core: format bytes go in,
// and every ASCII character that comes out is checked against a built-in formatter model or typed table text.
// Depends on mfa_pkg (character codes) and the core RTL only.
`timescale 1ns / 1ps

module mini_format_to_ascii_stream_core_test;

    localparam int N_DIRECTED  = 25;
    localparam int N_TOTAL     = 270;
    localparam int LONG_HOLD   = 80;
    localparam int TAIL_CYCLES = 40;

    // One expected output character
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_text_exp;

    // One row of the directed table; want is used only when typed is set
    typedef struct {
        logic [7:0]  fb;
        logic [31:0] arg;
        logic        fin;
        bit          typed;
        string       want;
    } t_fmt_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_format_byte;
    logic [31:0] i_argument_word;
    logic        i_string_end;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_text_char;
    logic        o_run_last;

    // Formatter model state and the characters it still expects
    logic        pct_held;
    logic [7:0]  next_chars[$];
    t_text_exp   text_expected[$];
    t_fmt_row    fmt_table[$];

    // Run bookkeeping
    int          items_sent;
    int          chars_checked;
    int          conversions;
    int          errors;
    bit          tx_idle;
    bit          rx_idle;
    int          hold_asked;
    int          hold_taken;

    mini_format_to_ascii_stream_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_format_byte   (i_format_byte),
        .i_argument_word (i_argument_word),
        .i_string_end    (i_string_end),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_text_char     (o_text_char),
        .o_run_last      (o_run_last)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Formatter model: fills next_chars with what one format byte produces
    function automatic void format_predict(input logic [7:0] fb, input logic [31:0] arg,
                                           input logic fin);
        logic [31:0] mag;
        logic [31:0] radix;
        logic [3:0]  digs[10];
        int          cnt;
        int          i;
        next_chars.delete();
        if (pct_held) begin
            pct_held = 1'b0;
            if (fb == mfa_pkg::CH_D || fb == mfa_pkg::CH_X) begin
                conversions++;
                radix = (fb == mfa_pkg::CH_D) ? 32'd10 : 32'd16;
                mag   = arg;
                // signed decimal: sign first, then magnitude (0x80000000 maps to itself)
                if (fb == mfa_pkg::CH_D && arg[31]) begin
                    next_chars.push_back(mfa_pkg::CH_MINUS);
                    mag = 32'd0 - arg;
                end
                cnt = 0;
                do begin
                    digs[cnt] = 4'(mag % radix);
                    mag       = mag / radix;
                    cnt++;
                end while (mag != 32'd0);
                for (i = cnt - 1; i >= 0; i--) begin
                    if (digs[i] < 4'd10)
                        next_chars.push_back(mfa_pkg::CH_ZERO + 8'(digs[i]));
                    else
                        next_chars.push_back(mfa_pkg::CH_A + 8'(digs[i]) - 8'd10);
                end
            end else begin
                next_chars.push_back(fb);
            end
        end else if (fb == mfa_pkg::CH_PERCENT) begin
            pct_held = !fin;
        end else begin
            next_chars.push_back(fb);
        end
        if (fin) pct_held = 1'b0;
    endfunction

    // Offer one format byte, wait for acceptance, then queue what it should produce
    task automatic send_item(input logic [7:0] fb, input logic [31:0] arg, input logic fin,
                             input bit typed, input string want);
        int gap;
        int k;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid         = 1'b1;
        i_format_byte   = fb;
        i_argument_word = arg;
        i_string_end    = fin;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        format_predict(fb, arg, fin);
        if (typed) begin
            next_chars.delete();
            for (k = 0; k < want.len(); k++) next_chars.push_back(8'(want[k]));
        end
        for (k = 0; k < next_chars.size(); k++)
            text_expected.push_back('{next_chars[k], k == next_chars.size() - 1});
    endtask

    // Stop offering and wait until every expected character has come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (text_expected.size() != 0) @(posedge i_clk);
    endtask

    // Argument mix: short numbers, small negatives, full range, extremes
    function automatic logic [31:0] pick_arg();
        case ($urandom_range(0, 4))
            0: return 32'($urandom_range(0, 99));
            1: return 32'd0 - 32'($urandom_range(1, 999));
            2, 3: return $urandom;
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'h8000_0000;
                    2: return 32'h7FFF_FFFF;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    // A well-formed format string with random content; sometimes ends on a lone '%'
    task automatic send_random_string();
        logic [7:0]  fbs[$];
        logic [31:0] args[$];
        int          len;
        int          k;
        int          pick;
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                fbs.push_back(8'($urandom_range(8'h20, 8'h7E)));
                args.push_back($urandom);
            end else if (pick < 8) begin
                fbs.push_back(mfa_pkg::CH_PERCENT);
                args.push_back($urandom);
                fbs.push_back(pick < 6 ? mfa_pkg::CH_D :
                              (pick == 6 ? mfa_pkg::CH_X : mfa_pkg::CH_PERCENT));
                args.push_back(pick_arg());
            end else if (pick == 8) begin
                fbs.push_back(mfa_pkg::CH_PERCENT);
                args.push_back($urandom);
                fbs.push_back(8'($urandom));
                args.push_back($urandom);
            end else begin
                fbs.push_back(8'($urandom));
                args.push_back($urandom);
            end
        end
        if ($urandom_range(0, 7) == 0) begin
            fbs.push_back(mfa_pkg::CH_PERCENT);
            args.push_back($urandom);
        end
        for (k = 0; k < fbs.size(); k++)
            send_item(fbs[k], args[k], k == fbs.size() - 1, 1'b0, "");
    endtask

    task automatic random_phase(input int upto);
        while (items_sent < upto) begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom), $urandom, $urandom_range(0, 3) == 0, 1'b0, "");
            else
                send_random_string();
        end
    endtask

    function automatic void add_row(input logic [7:0] fb, input logic [31:0] arg,
                                    input logic fin, input bit typed, input string want);
        fmt_table.push_back('{fb, arg, fin, typed, want});
    endfunction

    // Receiver: checks each accepted character, stalls at random or for a long hold
    initial begin
        int        rx_wait;
        int        hold_left;
        t_text_exp exp_ch;
        rx_wait   = 0;
        hold_left = 0;
        i_stall   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                chars_checked++;
                rx_wait = rx_idle ? $urandom_range(0, 3) : 0;
                if (text_expected.size() == 0) begin
                    $error("unexpected item: text_char %h run_last %b", o_text_char, o_run_last);
                    errors++;
                end else begin
                    exp_ch = text_expected.pop_front();
                    if (o_text_char !== exp_ch.ch) begin
                        $error("text_char expected %h actual %h", exp_ch.ch, o_text_char);
                        errors++;
                    end
                    if (o_run_last !== exp_ch.last) begin
                        $error("run_last expected %b actual %b", exp_ch.last, o_run_last);
                        errors++;
                    end
                end
            end
            @(negedge i_clk);
            if (hold_left == 0 && hold_taken != hold_asked) begin
                hold_taken++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else if (rx_wait > 0) begin
                i_stall = 1'b1;
                rx_wait--;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    // Sender and sequencing
    initial begin
        int r;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_format_byte   = 8'h00;
        i_argument_word = 32'h0;
        i_string_end    = 1'b0;
        pct_held        = 1'b0;
        items_sent      = 0;
        chars_checked   = 0;
        conversions     = 0;
        errors          = 0;
        tx_idle         = 1'b1;
        rx_idle         = 1'b1;
        hold_asked      = 0;
        hold_taken      = 0;

        // Directed table: typed text where obvious, model otherwise
        add_row(8'h41,               32'h0000_0000, 1'b0, 1'b1, "A");
        add_row(8'h00,               32'hFFFF_FFFF, 1'b0, 1'b0, "");  // zero byte is echoed
        add_row(8'hFF,               32'h0000_0000, 1'b1, 1'b0, "");
        add_row(mfa_pkg::CH_PERCENT, 32'h0000_0000, 1'b0, 1'b1, "");
        add_row(mfa_pkg::CH_D,       32'h0000_0000, 1'b0, 1'b1, "0");
        add_row(mfa_pkg::CH_PERCENT, 32'h0000_0000, 1'b0, 1'b1, "");
        add_row(mfa_pkg::CH_D,       32'h8000_0000, 1'b0, 1'b1, "-2147483648");
        add_row(mfa_pkg::CH_PERCENT, 32'h0000_0000, 1'b0, 1'b1, "");
        add_row(mfa_pkg::CH_D,       32'h7FFF_FFFF, 1'b0, 1'b1, "2147483647");
        add_row(mfa_pkg::CH_PERCENT, 32'h0000_0000, 1'b0, 1'b1, "");
        add_row(mfa_pkg::CH_D,       32'hFFFF_FFFF, 1'b1, 1'b1, "-1");  // conversion ends string
        add_row(mfa_pkg::CH_PERCENT, 32'h0000_0000, 1'b0, 1'b1, "");
        add_row(mfa_pkg::CH_X,       32'h0000_0000, 1'b0, 1'b1, "0");
        add_row(mfa_pkg::CH_PERCENT, 32'h0000_0000, 1'b0, 1'b1, "");
        add_row(mfa_pkg::CH_X,       32'hFFFF_FFFF, 1'b0, 1'b1, "ffffffff");
        add_row(mfa_pkg::CH_PERCENT, 32'h0000_0000, 1'b0, 1'b1, "");
        add_row(mfa_pkg::CH_PERCENT, 32'h0000_0000, 1'b0, 1'b1, "%");   // double percent
        add_row(mfa_pkg::CH_PERCENT, 32'h0000_0000, 1'b0, 1'b1, "");
        add_row(8'h71,               32'h1234_5678, 1'b0, 1'b1, "q");   // unknown letter
        add_row(mfa_pkg::CH_PERCENT, 32'h0000_0000, 1'b1, 1'b1, "");    // lone percent at end
        add_row(mfa_pkg::CH_D,       32'h0000_0007, 1'b0, 1'b1, "d");   // nothing pending
        add_row(mfa_pkg::CH_PERCENT, 32'h0000_0000, 1'b0, 1'b1, "");
        add_row(mfa_pkg::CH_D,       32'hFFFF_D8F1, 1'b0, 1'b0, "");
        add_row(mfa_pkg::CH_PERCENT, 32'h0000_0000, 1'b0, 1'b0, "");    // new conversion next
        add_row(mfa_pkg::CH_X,       32'hDEAD_BEEF, 1'b1, 1'b0, "");

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (r = 0; r < fmt_table.size(); r++)
            send_item(fmt_table[r].fb, fmt_table[r].arg, fmt_table[r].fin,
                      fmt_table[r].typed, fmt_table[r].want);

        // Random strings with gaps on both sides
        random_phase(N_DIRECTED + 70);
        wait_drained();

        // Back to back, no idling anywhere
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        random_phase(N_DIRECTED + 140);

        // Receiver holds off for a long stretch while conversions keep coming
        hold_asked++;
        for (r = 0; r < 10; r++) begin
            send_item(mfa_pkg::CH_PERCENT, $urandom, 1'b0, 1'b0, "");
            send_item(r[0] ? mfa_pkg::CH_X : mfa_pkg::CH_D, pick_arg(), r == 9, 1'b0, "");
        end
        wait_drained();

        // Mixed traffic with idling again
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        random_phase(N_TOTAL);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d format bytes, %0d conversions, %0d characters checked.",
                 items_sent, conversions, chars_checked);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[mini_format_to_ascii_stream_core.f]
sv/mfa_pkg.sv
sv/mfa_front.sv
sv/mfa_queue.sv
sv/mfa_back.sv
sv/mini_format_to_ascii_stream_core.sv
dv/mini_format_to_ascii_stream_core_test.sv
